// ===== rtl/core/gfp_pkg.sv =====
// shared types and constants for the grid fuel path block
package gfp_pkg;

   // largest grid side the line buffer holds
   localparam int SIDE_MAX = 16;
   localparam int IDX_W    = $clog2(SIDE_MAX);

   // field widths
   localparam int GRID_W = 5;
   localparam int COST_W = 16;
   localparam int FUEL_W = 24;

   // stream widths, packed fields filled up to whole bytes
   localparam int REQ_BITS = 1 + 3 * COST_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + FUEL_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // register reset value and fuel ceiling
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(SIDE_MAX);
   localparam logic [FUEL_W-1:0] FUEL_SAT   = {FUEL_W{1'b1}};

   // one grid cell as it arrives
   typedef struct packed {
      logic [COST_W-1:0] cost_from_above;
      logic [COST_W-1:0] cost_from_left;
      logic [COST_W-1:0] fuel;
      logic              blocked;
   } cell_type;

   // the corner report
   typedef struct packed {
      logic [FUEL_W-1:0] fuel_left;
      logic              reachable;
   } result_type;

   // handshake between the compute stage and the result register
   typedef struct packed {
      logic out_free;
      logic load;
   } rsp_ctrl_type;

endpackage

// ===== rtl/core/gfp_cell_reg.sv =====
// input register that holds one cell for the compute stage
module gfp_cell_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [gfp_pkg::REQ_W-1:0]  req_tdata,
   output logic                       cell_valid,
   output gfp_pkg::cell_type          cur_cell,
   input  logic                       cell_take
);

   logic              valid_ff;
   logic              valid_in;
   gfp_pkg::cell_type cell_ff;

   // room when empty or when the held cell leaves this cycle
   assign req_tready = !valid_ff || cell_take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload loads on every transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cell_ff <= gfp_pkg::cell_type'(req_tdata[gfp_pkg::REQ_BITS-1:0]);
      end
   end

   assign cell_valid = valid_ff;
   assign cur_cell   = cell_ff;

endmodule

// ===== rtl/core/gfp_dp_core.sv =====
// per-cell dynamic programming step with line buffer, left register and position
module gfp_dp_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [gfp_pkg::GRID_W-1:0]     csr_wr_data,
   input  logic                           cell_valid,
   input  gfp_pkg::cell_type              cur_cell,
   output logic                           cell_take,
   input  gfp_pkg::rsp_ctrl_type          rsp_in,
   output gfp_pkg::rsp_ctrl_type          rsp_out,
   output gfp_pkg::result_type            result
);

   localparam int IW = gfp_pkg::IDX_W;
   localparam int FW = gfp_pkg::FUEL_W;

   logic [gfp_pkg::GRID_W-1:0] grid_ff;
   logic [IW-1:0]              row_ff;
   logic [IW-1:0]              row_in;
   logic [IW-1:0]              col_ff;
   logic [IW-1:0]              col_in;
   logic [FW-1:0]              left_best_ff;
   logic [FW-1:0]              left_best_in;
   logic                       left_reach_ff;
   logic                       left_reach_in;

   // line buffer of the row above
   logic [FW-1:0]              column_best [gfp_pkg::SIDE_MAX];
   logic [gfp_pkg::SIDE_MAX-1:0] column_reach;

   logic [gfp_pkg::GRID_W-1:0] side;
   logic [IW-1:0]              last_idx;
   logic                       last_col;
   logic                       last_cell;
   logic [FW-1:0]              above_best;
   logic                       above_reach;
   logic                       left_ok;
   logic                       above_ok;
   logic [FW:0]                left_sum;
   logic [FW:0]                above_sum;
   logic [FW-1:0]              left_val;
   logic [FW-1:0]              above_val;
   logic [FW-1:0]              best;
   logic                       reach;

   // side in use, clamped to one through the buffer depth
   always_comb begin
      priority if (grid_ff == '0) begin
         side = gfp_pkg::GRID_W'(1);
      end else if (grid_ff > gfp_pkg::GRID_W'(gfp_pkg::SIDE_MAX)) begin
         side = gfp_pkg::GRID_W'(gfp_pkg::SIDE_MAX);
      end else begin
         side = grid_ff;
      end
   end

   assign last_idx  = IW'(side - gfp_pkg::GRID_W'(1));
   assign last_col  = (col_ff == last_idx);
   assign last_cell = last_col && (row_ff == last_idx);

   // a cell moves on unless it finishes the grid and the result slot is full
   assign cell_take = cell_valid && (!last_cell || rsp_in.out_free);

   // candidate moves from the left and from above
   assign above_best  = column_best[col_ff];
   assign above_reach = column_reach[col_ff];
   assign left_ok  = (col_ff != '0) && left_reach_ff
                     && (left_best_ff >= FW'(cur_cell.cost_from_left));
   assign above_ok = (row_ff != '0) && above_reach
                     && (above_best >= FW'(cur_cell.cost_from_above));
   assign left_sum  = {1'b0, left_best_ff - FW'(cur_cell.cost_from_left)}
                      + (FW+1)'(cur_cell.fuel);
   assign above_sum = {1'b0, above_best - FW'(cur_cell.cost_from_above)}
                      + (FW+1)'(cur_cell.fuel);
   assign left_val  = left_sum[FW]  ? gfp_pkg::FUEL_SAT : left_sum[FW-1:0];
   assign above_val = above_sum[FW] ? gfp_pkg::FUEL_SAT : above_sum[FW-1:0];

   // best of the allowed moves
   always_comb begin
      best  = '0;
      reach = 1'b0;
      if (!cur_cell.blocked) begin
         priority if (row_ff == '0 && col_ff == '0) begin
            best  = FW'(cur_cell.fuel);
            reach = 1'b1;
         end else if (left_ok && above_ok) begin
            best  = (above_val > left_val) ? above_val : left_val;
            reach = 1'b1;
         end else if (left_ok) begin
            best  = left_val;
            reach = 1'b1;
         end else if (above_ok) begin
            best  = above_val;
            reach = 1'b1;
         end else begin
            best  = '0;
            reach = 1'b0;
         end
      end
   end

   // position and left register advance
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      left_best_in  = left_best_ff;
      left_reach_in = left_reach_ff;
      if (csr_wr_en) begin
         row_in        = '0;
         col_in        = '0;
         left_best_in  = '0;
         left_reach_in = 1'b0;
      end else if (cell_take) begin
         if (last_col) begin
            col_in        = '0;
            left_best_in  = '0;
            left_reach_in = 1'b0;
            row_in        = (row_ff == last_idx) ? '0 : row_ff + IW'(1);
         end else begin
            col_in        = col_ff + IW'(1);
            left_best_in  = best;
            left_reach_in = reach;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff       <= gfp_pkg::GRID_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         left_best_ff  <= '0;
         left_reach_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            grid_ff <= csr_wr_data;
         end
         row_ff        <= row_in;
         col_ff        <= col_in;
         left_best_ff  <= left_best_in;
         left_reach_ff <= left_reach_in;
      end
   end

   // line buffer write, read happens before the write in the same cycle
   always_ff @(posedge clock) begin
      if (cell_take) begin
         column_best[col_ff]  <= best;
         column_reach[col_ff] <= reach;
      end
   end

   // report the corner on the last cell of the grid
   assign rsp_out.load     = cell_take && last_cell;
   assign rsp_out.out_free = rsp_in.out_free;
   assign result.reachable = reach;
   assign result.fuel_left = best;

endmodule

// ===== rtl/core/gfp_rsp_reg.sv =====
// result register that holds the corner report until the receiver takes it
module gfp_rsp_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  gfp_pkg::rsp_ctrl_type      ctrl_in,
   input  gfp_pkg::result_type        result,
   output gfp_pkg::rsp_ctrl_type      ctrl_out,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [gfp_pkg::RSP_W-1:0]  rsp_tdata
);

   logic                valid_ff;
   logic                valid_in;
   gfp_pkg::result_type result_ff;

   // slot frees when empty or on the transfer out
   assign ctrl_out.out_free = !valid_ff || rsp_tready;
   assign ctrl_out.load     = ctrl_in.load;
   assign valid_in          = ctrl_in.load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = gfp_pkg::RSP_W'(result_ff);

endmodule

// ===== rtl/core/grid_fuel_path_dp.sv =====
// top level of the grid fuel path block
//
// Cells of a square grid arrive in row-major order on the req_ stream, one
// transfer per cell. Each cell carries its blocked flag, its fuel and the cost
// of entering it from the left and from above. After the last cell of a grid
// one transfer on the rsp_ stream reports whether the far corner is reachable
// and the best fuel left there; no other cell produces a result.
// Throughput is one cell per cycle, set by the single compute stage that reads
// the column line buffer and the left register, bar the stall below. The report
// passes the input and result registers to rsp_tvalid. The grid side comes from
// csr_wr_data when csr_wr_en is high; a write restarts the grid at the first
// cell. The user writes only while no cell is in flight; the block does not
// check. Reset sets the side to 16, empties both registers and restarts the
// grid. When the receiver stalls, the report waits in the result register while
// cells of the next grid keep flowing; only the next grid's last cell waits.
module grid_fuel_path_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [gfp_pkg::GRID_W-1:0]   csr_wr_data,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // blocked, fuel, cost_from_left, cost_from_above, zero fill
   input  logic [gfp_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // reachable, fuel_left, zero fill
   output logic [gfp_pkg::RSP_W-1:0]    rsp_tdata
);

   logic                  cell_valid;
   logic                  cell_take;
   gfp_pkg::cell_type     cur_cell;
   gfp_pkg::rsp_ctrl_type core_ctrl;
   gfp_pkg::rsp_ctrl_type slot_ctrl;
   gfp_pkg::result_type   result;

   gfp_cell_reg u_cell_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cell_valid (cell_valid),
      .cur_cell   (cur_cell),
      .cell_take  (cell_take)
   );

   gfp_dp_core u_dp_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cell_valid  (cell_valid),
      .cur_cell    (cur_cell),
      .cell_take   (cell_take),
      .rsp_in      (slot_ctrl),
      .rsp_out     (core_ctrl),
      .result      (result)
   );

   gfp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (core_ctrl),
      .result     (result),
      .ctrl_out   (slot_ctrl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb_top.sv =====
// self-checking stream testbench for the grid fuel path block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // content mixes for random cells
   localparam int MIX_WIDE  = 0;
   localparam int MIX_TIGHT = 1;
   localparam int MIX_EASY  = 2;

   // receiver pacing modes
   localparam int PACE_FREE = 0;
   localparam int PACE_HALF = 1;
   localparam int PACE_SLOW = 2;
   localparam int PACE_BUSY = 3;

   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 4;
   localparam int CYCLE_LIMIT = 200000;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [gfp_pkg::GRID_W-1:0]   csr_wr_data = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [gfp_pkg::REQ_W-1:0]    req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [gfp_pkg::RSP_W-1:0]    rsp_tdata;

   // cells waiting for the driver and corner reports waiting for the monitor
   gfp_pkg::cell_type   pending[$];
   gfp_pkg::result_type corner_q[$];
   gfp_pkg::cell_type   cell_on_bus;

   // predictor state
   logic [gfp_pkg::GRID_W-1:0] side_set = gfp_pkg::GRID_RESET;
   int unsigned       col_best[gfp_pkg::SIDE_MAX];
   bit                col_reach[gfp_pkg::SIDE_MAX];
   int unsigned       left_best = 0;
   bit                left_reach = 1'b0;
   int unsigned       row_at = 0;
   int unsigned       col_at = 0;

   int  err_count = 0;
   int  reports_checked = 0;
   int  cells_sent = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   int  pace_cnt = 0;
   int  pace_mode = PACE_FREE;
   bit  hold_kick = 1'b0;
   bit  hold_done = 1'b0;
   int  cycle_cnt = 0;

   grid_fuel_path_dp dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // position back to the first cell, left neighbor empty
   function automatic void clear_position();
      row_at = 0;
      col_at = 0;
      left_best = 0;
      left_reach = 1'b0;
   endfunction

   function automatic gfp_pkg::cell_type cell_of(input bit blk, input int f, input int cl,
                                                 input int ca);
      gfp_pkg::cell_type c;
      c.blocked = blk;
      c.fuel = f[gfp_pkg::COST_W-1:0];
      c.cost_from_left = cl[gfp_pkg::COST_W-1:0];
      c.cost_from_above = ca[gfp_pkg::COST_W-1:0];
      return c;
   endfunction

   function automatic gfp_pkg::cell_type rand_cell(input int mix);
      gfp_pkg::cell_type c;
      unique case (mix)
         MIX_WIDE: begin
            c.blocked = ($urandom_range(0, 7) == 0);
            c.fuel = gfp_pkg::COST_W'($urandom);
            c.cost_from_left = gfp_pkg::COST_W'($urandom);
            c.cost_from_above = gfp_pkg::COST_W'($urandom);
         end
         MIX_TIGHT: begin
            c.blocked = ($urandom_range(0, 11) == 0);
            c.fuel = gfp_pkg::COST_W'($urandom_range(0, 3000));
            c.cost_from_left = gfp_pkg::COST_W'($urandom_range(0, 2000));
            c.cost_from_above = gfp_pkg::COST_W'($urandom_range(0, 2000));
         end
         default: begin
            c.blocked = ($urandom_range(0, 19) == 0);
            c.fuel = gfp_pkg::COST_W'($urandom);
            c.cost_from_left = $urandom_range(0, 1) ? 16'd0 : gfp_pkg::COST_W'($urandom);
            c.cost_from_above = $urandom_range(0, 1) ? 16'd0 : gfp_pkg::COST_W'($urandom);
         end
      endcase
      return c;
   endfunction

   // best fuel through one cell; a corner report is expected after the last cell
   task automatic predict_cell(input gfp_pkg::cell_type c);
      int unsigned         side, r, k, cand, best, sat;
      bit                  reach;
      gfp_pkg::result_type rep;
      sat = 32'(gfp_pkg::FUEL_SAT);
      side = (side_set == 0) ? 1 : (side_set > gfp_pkg::SIDE_MAX) ? gfp_pkg::SIDE_MAX : side_set;
      if (row_at >= side || col_at >= side) clear_position();
      r = row_at;
      k = col_at;
      reach = 1'b0;
      best = 0;
      if (!c.blocked) begin
         if (r == 0 && k == 0) begin
            reach = 1'b1;
            best = 32'(c.fuel);
         end else begin
            if (k > 0 && left_reach && left_best >= c.cost_from_left) begin
               cand = left_best - c.cost_from_left + c.fuel;
               best = (cand > sat) ? sat : cand;
               reach = 1'b1;
            end
            if (r > 0 && col_reach[k] && col_best[k] >= c.cost_from_above) begin
               cand = col_best[k] - c.cost_from_above + c.fuel;
               if (cand > sat) cand = sat;
               if (!reach || cand > best) best = cand;
               reach = 1'b1;
            end
         end
      end
      col_best[k] = best;
      col_reach[k] = reach;
      left_best = best;
      left_reach = reach;
      if (k + 1 < side) begin
         col_at = k + 1;
      end else begin
         col_at = 0;
         left_best = 0;
         left_reach = 1'b0;
         if (r + 1 < side) begin
            row_at = r + 1;
         end else begin
            row_at = 0;
            rep.reachable = reach;
            rep.fuel_left = gfp_pkg::FUEL_W'(best);
            corner_q.push_back(rep);
         end
      end
   endtask

   // nothing queued, nothing on the bus, no report outstanding, pipeline drained
   task automatic wait_idle();
      do begin
         while (!(pending.size() == 0 && !req_tvalid && corner_q.size() == 0))
            @(posedge clock);
         repeat (DRAIN_WAIT) @(posedge clock);
      end while (!(pending.size() == 0 && !req_tvalid && corner_q.size() == 0));
   endtask

   task automatic write_side(input logic [gfp_pkg::GRID_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      side_set = value;
      clear_position();
   endtask

   task automatic queue_cells(input int count, input int mix);
      for (int n = 0; n < count; n++) pending.push_back(rand_cell(mix));
   endtask

   // driver: one item per transfer, bursts sometimes separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_cell(cell_on_bus);
            cells_sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending.size() > 0) begin
            cell_on_bus = pending.pop_front();
            req_tdata <= {{(gfp_pkg::REQ_W - gfp_pkg::REQ_BITS){1'b0}}, cell_on_bus};
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: one long hold when asked, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_kick && !hold_done) begin
         hold_left = LONG_HOLD;
         hold_done = 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         if (pace_cnt == 0) begin
            pace_mode = $urandom_range(PACE_FREE, PACE_BUSY);
            pace_cnt = $urandom_range(20, 80);
         end else begin
            pace_cnt--;
         end
         unique case (pace_mode)
            PACE_FREE: rsp_tready <= 1'b1;
            PACE_HALF: rsp_tready <= ($urandom_range(0, 1) == 1);
            PACE_SLOW: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor: each report transfer against the oldest expectation
   always @(posedge clock) begin
      gfp_pkg::result_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[gfp_pkg::RSP_BITS-1:0];
         if (corner_q.size() == 0) begin
            $error("unexpected corner report: reachable %0b fuel_left %0d",
                   seen.reachable, seen.fuel_left);
            err_count++;
         end else begin
            want = corner_q.pop_front();
            if (seen.reachable !== want.reachable) begin
               $error("reachable: expected %0b, actual %0b", want.reachable, seen.reachable);
               err_count++;
            end
            if (seen.fuel_left !== want.fuel_left) begin
               $error("fuel_left: expected %0d, actual %0d", want.fuel_left, seen.fuel_left);
               err_count++;
            end
            reports_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("FAIL grid_fuel_path_dp");
         $finish;
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int                         phase;
      int                         rand_cells;
      int                         grids;
      int                         eff;
      int                         mix;
      int                         part;
      logic [gfp_pkg::GRID_W-1:0] side;
      phase = 0;
      rand_cells = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single-cell grids: blocked start, empty start, full fuel with ignored costs
      write_side(5'd1);
      pending.push_back(cell_of(1, 5, 0, 0));
      pending.push_back(cell_of(0, 0, 0, 0));
      pending.push_back(cell_of(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));

      // side zero behaves as one
      write_side(5'd0);
      pending.push_back(cell_of(1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending.push_back(cell_of(0, 16'h1234, 0, 0));

      // 2x2: exact cost allowed, cost above fuel refused, corner from above
      write_side(5'd2);
      pending.push_back(cell_of(0, 10, 0, 0));
      pending.push_back(cell_of(0, 5, 10, 0));
      pending.push_back(cell_of(0, 0, 0, 11));
      pending.push_back(cell_of(0, 7, 3, 5));
      // blocked neighbor above the corner, corner from the left only
      pending.push_back(cell_of(0, 100, 0, 0));
      pending.push_back(cell_of(1, 9, 0, 0));
      pending.push_back(cell_of(0, 0, 0, 40));
      pending.push_back(cell_of(0, 3, 20, 0));
      // both moves allowed, the better one wins
      pending.push_back(cell_of(0, 100, 0, 0));
      pending.push_back(cell_of(0, 0, 0, 0));
      pending.push_back(cell_of(0, 0, 0, 0));
      pending.push_back(cell_of(0, 1, 30, 10));

      // partial grid, then a rewrite restarts at the first cell
      write_side(5'd3);
      pending.push_back(cell_of(0, 200, 0, 0));
      pending.push_back(cell_of(0, 1, 50, 0));
      pending.push_back(cell_of(0, 2, 100, 0));
      pending.push_back(cell_of(0, 3, 0, 150));
      write_side(5'd2);
      repeat (4) pending.push_back(cell_of(0, 16'hFFFF, 0, 0));

      // random grids of mixed sides, a few full size
      while (rand_cells < 950) begin
         if (phase == 2) side = 5'd16;
         else if (phase == 4) side = 5'd1;
         else if (phase == 6) side = 5'd31;
         else begin
            case ($urandom_range(0, 9))
               0:       side = 5'd0;
               8, 9:    side = gfp_pkg::GRID_W'($urandom_range(6, 9));
               default: side = gfp_pkg::GRID_W'($urandom_range(2, 5));
            endcase
         end
         write_side(side);
         eff = (side == 0) ? 1 : (side > gfp_pkg::SIDE_MAX) ? gfp_pkg::SIDE_MAX : side;
         grids = (eff == gfp_pkg::SIDE_MAX) ? 1 : (phase == 4) ? 40 : $urandom_range(1, 5);
         mix = $urandom_range(MIX_WIDE, MIX_EASY);
         // single-cell grids fill the block while the receiver holds off
         if (phase == 4) hold_kick <= 1'b1;
         queue_cells(grids * eff * eff, mix);
         rand_cells += grids * eff * eff;
         if (eff > 1 && eff < gfp_pkg::SIDE_MAX && $urandom_range(0, 4) == 0) begin
            part = $urandom_range(1, eff * eff - 1);
            queue_cells(part, mix);
            rand_cells += part;
         end
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("run covered %0d cells and %0d corner reports over %0d grid settings",
               cells_sent, reports_checked, phase + 5);
      $display("sides 0 through 9, 16 and 31 written, partial grids, one long receiver hold");
      if (err_count == 0) begin
         $display("PASS grid_fuel_path_dp");
      end else begin
         $display("FAIL grid_fuel_path_dp");
      end
      $finish;
   end

endmodule
